// ===== hw/rtl/rpes_pkg.sv =====
// Shared constants, types and codes of the RTP payload equal split block.
package rpes_pkg;

	localparam int MAX_PACKETS = 64;
	localparam int LEN_BITS = 16;

	localparam int LW = (LEN_BITS < 16) ? LEN_BITS : 16;
	localparam int SUM_W = ((LW > 13) ? LW : 13) + 1;
	localparam int DIV_W = (SUM_W > 16) ? SUM_W : 16;
	localparam int DCNT_W = $clog2(DIV_W + 1);
	localparam int CNT_W = $clog2(MAX_PACKETS + 1);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
	localparam logic [1:0] REG_FIRST_OH = 2'd1;
	localparam logic [1:0] REG_LAST_OH = 2'd2;
	localparam logic [1:0] REG_SINGLE_OH = 2'd3;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFIT = 2'd1,
		ST_OVER = 2'd2
	} status_t;

	typedef enum logic {
		JOB_WORD = 1'b0,
		JOB_RUN = 1'b1
	} kind_t;

	typedef struct packed {
		logic [15:0] max_payload;
		logic [11:0] first_oh;
		logic [11:0] last_oh;
		logic [11:0] single_oh;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic [LW-1:0] bytes;
		status_t status;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] base;
		logic [CNT_W-1:0] larger;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/rpes_div.sv =====
// Restoring serial divider producing one quotient bit per cycle.
module rpes_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rpes_pkg::DIV_W-1:0] dividend,
	input  logic [rpes_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [rpes_pkg::DIV_W-1:0] quotient,
	output logic [rpes_pkg::DIV_W-1:0] remainder
);

	logic                        run_q;
	logic                        done_q;
	logic [rpes_pkg::DCNT_W-1:0] cnt_q;
	logic [rpes_pkg::DIV_W-1:0]  rem_q;
	logic [rpes_pkg::DIV_W-1:0]  quo_q;
	logic [rpes_pkg::DIV_W-1:0]  dvs_q;
	logic [rpes_pkg::DIV_W:0]    trial;
	logic                        take;
	logic [rpes_pkg::DIV_W-1:0]  rem_n;

	always_comb begin
		trial = {rem_q, quo_q[rpes_pkg::DIV_W-1]};
		take = (trial >= {1'b0, dvs_q});
		if (take) begin
			rem_n = rpes_pkg::DIV_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_n = trial[rpes_pkg::DIV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= rpes_pkg::DCNT_W'(rpes_pkg::DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rpes_pkg::DCNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[rpes_pkg::DIV_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/rpes_fifo.sv =====
// Short job queue between the front and the back of the split block.
module rpes_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  rpes_pkg::q_ctl_t  ctl,
	input  rpes_pkg::job_t    wr_job,
	output rpes_pkg::job_t    rd_job,
	output rpes_pkg::q_stat_t stat
);

	rpes_pkg::job_t              mem_q [rpes_pkg::QDEPTH];
	logic [rpes_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rpes_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rpes_pkg::QCNT_W-1:0] cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign stat.full = (cnt_q == rpes_pkg::QCNT_W'(rpes_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push = ctl.push && !stat.full;
	assign do_pop = ctl.pop && !stat.empty;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == rpes_pkg::QPTR_W'(rpes_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == rpes_pkg::QPTR_W'(rpes_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== hw/rtl/rpes_front.sv =====
// Front end: accepts a payload length, classifies it and computes the split.
module rpes_front (
	input  logic              clk,
	input  logic              arst_n,
	input  rpes_pkg::cfg_t    cfg,
	input  logic              start,
	input  logic [15:0]       payload_length,
	output logic              busy,
	input  rpes_pkg::q_stat_t q_stat,
	output logic              q_push,
	output rpes_pkg::job_t    q_job
);

	typedef enum logic [4:0] {
		F_IDLE  = 5'b00001,
		F_CLASS = 5'b00010,
		F_DIV1  = 5'b00100,
		F_DIV2  = 5'b01000,
		F_PUSH  = 5'b10000
	} fstate_t;

	fstate_t                    state_q;
	logic [rpes_pkg::LW-1:0]    pay_q;
	logic [rpes_pkg::DIV_W-1:0] total_q;
	logic [rpes_pkg::CNT_W-1:0] count_q;
	rpes_pkg::job_t             job_q;
	logic                       div_start_q;
	logic [rpes_pkg::DIV_W-1:0] dividend_q;
	logic [rpes_pkg::DIV_W-1:0] divisor_q;

	logic                       div_done;
	logic [rpes_pkg::DIV_W-1:0] div_quo;
	logic [rpes_pkg::DIV_W-1:0] div_rem;
	logic [rpes_pkg::DIV_W-1:0] pay_w;
	logic [rpes_pkg::DIV_W-1:0] maxp_w;
	logic [rpes_pkg::DIV_W-1:0] single_sum;
	logic [rpes_pkg::DIV_W-1:0] total_sum;
	logic [rpes_pkg::DIV_W-1:0] cnt_raw;
	logic [rpes_pkg::DIV_W-1:0] cnt;
	logic                       fits;
	logic                       cap_err;

	rpes_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start_q),
		.dividend  (dividend_q),
		.divisor   (divisor_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		pay_w = rpes_pkg::DIV_W'(pay_q);
		maxp_w = rpes_pkg::DIV_W'(cfg.max_payload);
		single_sum = pay_w + rpes_pkg::DIV_W'(cfg.single_oh);
		total_sum = pay_w + rpes_pkg::DIV_W'(cfg.first_oh) + rpes_pkg::DIV_W'(cfg.last_oh);
		fits = (maxp_w >= single_sum);
		cap_err = (cfg.max_payload <= 16'(cfg.first_oh)) ||
			(cfg.max_payload <= 16'(cfg.last_oh));
		cnt_raw = div_quo + rpes_pkg::DIV_W'(div_rem != '0);
		cnt = (cnt_raw == rpes_pkg::DIV_W'(1)) ? rpes_pkg::DIV_W'(2) : cnt_raw;
	end

	assign busy = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_stat.full;
	assign q_job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					if (fits || cap_err) begin
						state_q <= F_PUSH;
					end else begin
						div_start_q <= 1'b1;
						state_q <= F_DIV1;
					end
				end
				F_DIV1: begin
					if (div_done) begin
						if (pay_w < cnt || cnt > rpes_pkg::DIV_W'(rpes_pkg::MAX_PACKETS)) begin
							state_q <= F_PUSH;
						end else begin
							div_start_q <= 1'b1;
							state_q <= F_DIV2;
						end
					end
				end
				F_DIV2: begin
					if (div_done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_stat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (start) begin
					pay_q <= payload_length[rpes_pkg::LW-1:0];
				end
			end
			F_CLASS: begin
				job_q.kind <= rpes_pkg::JOB_WORD;
				job_q.count <= '0;
				job_q.base <= '0;
				job_q.larger <= '0;
				if (fits) begin
					job_q.bytes <= pay_q;
					job_q.status <= rpes_pkg::ST_OK;
				end else begin
					job_q.bytes <= '0;
					job_q.status <= rpes_pkg::ST_NOFIT;
				end
				total_q <= total_sum;
				dividend_q <= total_sum;
				divisor_q <= maxp_w;
			end
			F_DIV1: begin
				if (div_done) begin
					count_q <= rpes_pkg::CNT_W'(cnt);
					dividend_q <= total_q;
					divisor_q <= cnt;
					if (pay_w < cnt) begin
						job_q.status <= rpes_pkg::ST_NOFIT;
					end else begin
						job_q.status <= rpes_pkg::ST_OVER;
					end
				end
			end
			F_DIV2: begin
				if (div_done) begin
					job_q.kind <= rpes_pkg::JOB_RUN;
					job_q.bytes <= pay_q;
					job_q.status <= rpes_pkg::ST_OK;
					job_q.count <= count_q;
					job_q.base <= rpes_pkg::SUM_W'(div_quo);
					job_q.larger <= rpes_pkg::CNT_W'(div_rem);
				end
			end
			F_PUSH: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/rpes_back.sv =====
// Back end: takes jobs from the queue and, while it runs a split job, emits one packet size per cycle.
module rpes_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rpes_pkg::cfg_t    cfg,
	input  rpes_pkg::q_stat_t q_stat,
	input  rpes_pkg::job_t    q_job,
	output logic              q_pop,
	output logic              result_valid,
	output logic [15:0]       packet_bytes,
	output logic              last_packet,
	output logic [1:0]        status
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} bstate_t;

	bstate_t                    state_q;
	logic                       valid_q;
	logic [15:0]                bytes_q;
	logic                       last_q;
	rpes_pkg::status_t          status_q;
	logic [rpes_pkg::LW-1:0]    rem_q;
	logic [rpes_pkg::CNT_W-1:0] left_q;
	logic [rpes_pkg::SUM_W-1:0] base_q;
	logic [rpes_pkg::CNT_W-1:0] larger_q;
	logic                       first_q;

	logic [rpes_pkg::SUM_W-1:0] base_n;
	logic [rpes_pkg::SUM_W-1:0] fo_w;
	logic [rpes_pkg::SUM_W-1:0] rem_w;
	logic [rpes_pkg::SUM_W-1:0] cur0;
	logic [rpes_pkg::SUM_W-1:0] cur1;
	logic [rpes_pkg::SUM_W-1:0] cur2;
	logic [rpes_pkg::LW-1:0]    rem_n;
	logic [rpes_pkg::CNT_W-1:0] left_n;
	logic                       run_last;

	always_comb begin
		base_n = (left_q == larger_q) ? base_q + 1'b1 : base_q;
		fo_w = rpes_pkg::SUM_W'(cfg.first_oh);
		rem_w = rpes_pkg::SUM_W'(rem_q);
		cur0 = base_n;
		if (first_q) begin
			cur0 = (base_n > fo_w + 1'b1) ? base_n - fo_w : rpes_pkg::SUM_W'(1);
		end
		cur1 = (cur0 > rem_w) ? rem_w : cur0;
		cur2 = (left_q == rpes_pkg::CNT_W'(2) && cur1 == rem_w) ? cur1 - 1'b1 : cur1;
		rem_n = rem_q - cur2[rpes_pkg::LW-1:0];
		left_n = left_q - 1'b1;
		run_last = (rem_n == '0) || (left_n == '0);
	end

	assign q_pop = (state_q == B_IDLE) && !q_stat.empty;
	assign result_valid = valid_q;
	assign packet_bytes = bytes_q;
	assign last_packet = last_q;
	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						if (q_job.kind == rpes_pkg::JOB_WORD) begin
							valid_q <= 1'b1;
						end else begin
							state_q <= B_RUN;
						end
					end
				end
				B_RUN: begin
					valid_q <= 1'b1;
					if (run_last) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				bytes_q <= 16'(q_job.bytes);
				last_q <= 1'b1;
				status_q <= q_job.status;
				rem_q <= q_job.bytes;
				left_q <= q_job.count;
				base_q <= q_job.base;
				larger_q <= q_job.larger;
				first_q <= 1'b1;
			end
			B_RUN: begin
				bytes_q <= 16'(cur2);
				last_q <= run_last;
				status_q <= rpes_pkg::ST_OK;
				rem_q <= rem_n;
				left_q <= left_n;
				base_q <= base_n;
				first_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/rtp_payload_equal_split.sv =====
// Top level of the RTP payload equal split block with its configuration registers.
//
// Channel  Direction  Handshake              Word
// command  in         start, busy            payload_length
// result   out        result_valid strobe    packet_bytes, last_packet, status
// config   in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A length that fits one packet or fails a capacity check skips the divider in the front.
// A split runs two serial divisions in the front: the total by the maximum payload, then by the count.
// A count that would leave a packet without payload or exceeds the limit ends after the first division.
// The back answers a single-word job as it pops it; a split job it loads, then emits its sizes back to back.
// Reset clears all control state; the configuration registers return to their defaults.
// The result strobe cannot be held off; busy is high until the front has queued its job.
module rtp_payload_equal_split (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] payload_length,
	output logic        result_valid,
	output logic [15:0] packet_bytes,
	output logic        last_packet,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	rpes_pkg::cfg_t    cfg_q;
	rpes_pkg::q_ctl_t  q_ctl;
	rpes_pkg::q_stat_t q_stat;
	rpes_pkg::job_t    wr_job;
	rpes_pkg::job_t    rd_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload <= 16'd1200;
			cfg_q.first_oh <= '0;
			cfg_q.last_oh <= '0;
			cfg_q.single_oh <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpes_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data;
				rpes_pkg::REG_FIRST_OH: cfg_q.first_oh <= cfg_data[11:0];
				rpes_pkg::REG_LAST_OH: cfg_q.last_oh <= cfg_data[11:0];
				rpes_pkg::REG_SINGLE_OH: cfg_q.single_oh <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	rpes_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.start          (start),
		.payload_length (payload_length),
		.busy           (busy),
		.q_stat         (q_stat),
		.q_push         (q_ctl.push),
		.q_job          (wr_job)
	);

	rpes_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.wr_job (wr_job),
		.rd_job (rd_job),
		.stat   (q_stat)
	);

	rpes_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_stat       (q_stat),
		.q_job        (rd_job),
		.q_pop        (q_ctl.pop),
		.result_valid (result_valid),
		.packet_bytes (packet_bytes),
		.last_packet  (last_packet),
		.status       (status)
	);

endmodule
